// ===== rtl/core/aabb_body_table_stepper_core_assert.svh =====
// Assertion macros shared by the box table stepper modules.
// Each macro expects signals named clock and reset in the using scope.
`ifndef AABB_BODY_TABLE_STEPPER_CORE_ASSERT_SVH
`define AABB_BODY_TABLE_STEPPER_CORE_ASSERT_SVH
// Same-cycle implication.
`define ABTS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define ABTS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/core/abts_pkg.sv =====
// Package for the box table stepper: operation and status codes, table entry
// types, controller command and status structs, and the saturation helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package abts_pkg;

   localparam logic [2:0] OP_ADD_MOV = 3'd0;
   localparam logic [2:0] OP_ADD_FIX = 3'd1;
   localparam logic [2:0] OP_FORCE   = 3'd2;
   localparam logic [2:0] OP_SHIFT   = 3'd3;
   localparam logic [2:0] OP_SET     = 3'd4;
   localparam logic [2:0] OP_TICK    = 3'd5;
   localparam logic [2:0] OP_READ    = 3'd6;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;

   localparam logic [6:0] ID_SPACE = 7'd64;
   localparam logic [14:0] SPEED_LIMIT_RESET = 15'd160;

   typedef struct packed {
      logic        [5:0]  id;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic        [14:0] w;
      logic        [14:0] h;
   } mov_ent_type;

   typedef struct packed {
      logic        [5:0]  id;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic        [14:0] w;
      logic        [14:0] h;
   } fix_ent_type;

   typedef struct packed {
      logic        [1:0]  status;
      logic        [5:0]  id;
      logic               fixed;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic        [14:0] w;
      logic        [14:0] h;
   } res_type;

   typedef enum logic [3:0] {
      STEP_NONE, STEP_LOAD, STEP_SCAN_M, STEP_CLR, STEP_SCAN_F,
      STEP_TICK_RD, STEP_TICK_LD, STEP_TICK_F, STEP_TICK_WB
   } step_type;

   typedef enum logic [2:0] {
      FIN_NONE, FIN_ADD, FIN_NOTFOUND, FIN_APPLY_M, FIN_APPLY_F
   } fin_type;

   typedef struct packed {
      step_type step;
      fin_type  fin;
      logic     emit;
   } cmd_type;

   typedef struct packed {
      logic m_match;
      logic m_done;
      logic f_match;
      logic f_done;
      logic tick_more;
      logic tf_done;
      logic out_free;
   } stat_type;

   function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
      logic signed [15:0] r;
      if (v > 20'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -20'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/abts_ctrl.sv =====
// Controller state machine for the box table stepper.
// Depends on abts_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "aabb_body_table_stepper_core_assert.svh"
module abts_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [2:0]        req_op,
   output logic                   req_stall,
   output abts_pkg::cmd_type      cmd,
   input  wire abts_pkg::stat_type st
);
   import abts_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE    = 11'b00000000001,
      S_ADD     = 11'b00000000010,
      S_SCAN_M  = 11'b00000000100,
      S_SCAN_F  = 11'b00000001000,
      S_APPLY_M = 11'b00000010000,
      S_APPLY_F = 11'b00000100000,
      S_TICK_RD = 11'b00001000000,
      S_TICK_LD = 11'b00010000000,
      S_TICK_F  = 11'b00100000000,
      S_TICK_WB = 11'b01000000000,
      S_RESP    = 11'b10000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '{step: STEP_NONE, fin: FIN_NONE, emit: 1'b0};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.step = STEP_LOAD;
               op_in    = req_op;
               case (req_op) inside
                  OP_ADD_MOV, OP_ADD_FIX:            state_in = S_ADD;
                  OP_FORCE, OP_SHIFT, OP_SET, OP_READ: state_in = S_SCAN_M;
                  OP_TICK:                           state_in = S_TICK_RD;
                  default:                           state_in = S_RESP;
               endcase
            end
         end
         S_ADD: begin
            cmd.fin  = FIN_ADD;
            state_in = S_RESP;
         end
         S_SCAN_M: begin
            cmd.step = STEP_SCAN_M;
            if (st.m_match) begin
               state_in = S_APPLY_M;
            end else if (st.m_done) begin
               if (op_ff == OP_SET || op_ff == OP_READ) begin
                  cmd.step = STEP_CLR;
                  state_in = S_SCAN_F;
               end else begin
                  cmd.fin  = FIN_NOTFOUND;
                  state_in = S_RESP;
               end
            end
         end
         S_SCAN_F: begin
            cmd.step = STEP_SCAN_F;
            if (st.f_match) begin
               state_in = S_APPLY_F;
            end else if (st.f_done) begin
               cmd.fin  = FIN_NOTFOUND;
               state_in = S_RESP;
            end
         end
         S_APPLY_M: begin
            cmd.fin  = FIN_APPLY_M;
            state_in = S_RESP;
         end
         S_APPLY_F: begin
            cmd.fin  = FIN_APPLY_F;
            state_in = S_RESP;
         end
         S_TICK_RD: begin
            cmd.step = STEP_TICK_RD;
            state_in = st.tick_more ? S_TICK_LD : S_RESP;
         end
         S_TICK_LD: begin
            cmd.step = STEP_TICK_LD;
            state_in = S_TICK_F;
         end
         S_TICK_F: begin
            cmd.step = STEP_TICK_F;
            if (st.tf_done) begin
               state_in = S_TICK_WB;
            end
         end
         S_TICK_WB: begin
            cmd.step = STEP_TICK_WB;
            state_in = S_TICK_RD;
         end
         S_RESP: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_ADD_MOV;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   `ABTS_ASSERT_NXT(a_leave_idle, accept, state_ff != S_IDLE, "accepted item left controller idle")
   `ABTS_ASSERT_IMP(a_emit_free, cmd.emit, st.out_free, "result emitted into a busy output")
   `ABTS_ASSERT_NXT(a_hit_apply, state_ff == S_SCAN_M && st.m_match, state_ff == S_APPLY_M,
                    "moving hit not applied")

endmodule
`default_nettype wire

// ===== rtl/core/abts_dp.sv =====
// Datapath for the box table stepper: box table memories, counters, work
// registers, bounce logic and the result register. Depends on abts_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "aabb_body_table_stepper_core_assert.svh"
module abts_dp #(
   parameter int MOVING_MAX = 32,
   parameter int FIXED_MAX  = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [14:0]        csr_write_data,
   input  wire logic [2:0]         req_op,
   input  wire logic [5:0]         req_body_id,
   input  wire logic signed [15:0] req_coord_x,
   input  wire logic signed [15:0] req_coord_y,
   input  wire logic signed [15:0] req_rate_x,
   input  wire logic signed [15:0] req_rate_y,
   input  wire logic [14:0]        req_width,
   input  wire logic [14:0]        req_height,
   input  wire logic               rsp_stall,
   output logic                    rsp_valid,
   output abts_pkg::res_type       rsp_res,
   input  wire abts_pkg::cmd_type  cmd,
   output abts_pkg::stat_type      st
);
   import abts_pkg::*;

   localparam int MAW = (MOVING_MAX > 1) ? $clog2(MOVING_MAX) : 1;
   localparam int FAW = (FIXED_MAX > 1) ? $clog2(FIXED_MAX) : 1;
   localparam int MCW = $clog2(MOVING_MAX + 1);
   localparam int FCW = $clog2(FIXED_MAX + 1);
   localparam int ICW = (MCW > FCW) ? MCW : FCW;

   mov_ent_type mov_mem [MOVING_MAX];
   fix_ent_type fix_mem [FIXED_MAX];
   mov_ent_type mrd_ff, mwd, apply_ent;
   fix_ent_type frd_ff, fwd;
   logic mre, mwe, fre, fwe;
   logic [MAW-1:0] mra, mwa, mraddr_ff, widx_ff;
   logic [FAW-1:0] fra, fwa, fraddr_ff, fwidx_ff;

   logic [14:0]    lim_ff;
   logic [MCW-1:0] mcnt_ff;
   logic [FCW-1:0] fcnt_ff;
   logic [6:0]     next_id_ff;
   logic [ICW-1:0] idx_ff;
   logic [FCW-1:0] fidx_ff;
   logic           mrv_ff, frv_ff, rsp_valid_ff;

   logic [2:0]         op_ff;
   logic [5:0]         id_ff;
   logic signed [15:0] cx_ff, cy_ff, rx_ff, ry_ff;
   logic [14:0]        w_ff, h_ff;
   mov_ent_type        work_ff;
   res_type            res_ff, rsp_ff;

   logic idx_m_ok, idx_f_ok, fidx_ok, full, add_ok;
   logic signed [19:0] bx, by, bvx, bvy, bw, bh, bfl, bft, bfr, bfb;
   logic signed [19:0] box, boy, bxw, byh, boxw, boyh, ax, ay, lim_s;
   logic hit, hx, hy;

   assign idx_m_ok = idx_ff < ICW'(mcnt_ff);
   assign idx_f_ok = idx_ff < ICW'(fcnt_ff);
   assign fidx_ok  = fidx_ff < fcnt_ff;
   assign full = (next_id_ff >= ID_SPACE) ||
                 ((op_ff == OP_ADD_MOV) ? (mcnt_ff >= MCW'(MOVING_MAX))
                                        : (fcnt_ff >= FCW'(FIXED_MAX)));
   assign add_ok = (cmd.fin == FIN_ADD) && !full;

   always_comb begin
      st.m_match   = mrv_ff && (mrd_ff.id == id_ff);
      st.m_done    = !idx_m_ok && !mrv_ff;
      st.f_match   = frv_ff && (frd_ff.id == id_ff);
      st.f_done    = !idx_f_ok && !frv_ff;
      st.tick_more = idx_m_ok;
      st.tf_done   = !fidx_ok && !frv_ff;
      st.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Bounce test of the work box against the fixed box just read.
   always_comb begin
      bx   = 20'(work_ff.px);
      by   = 20'(work_ff.py);
      bvx  = 20'(work_ff.vx);
      bvy  = 20'(work_ff.vy);
      bw   = signed'(20'(work_ff.w));
      bh   = signed'(20'(work_ff.h));
      bfl  = 20'(frd_ff.px);
      bft  = 20'(frd_ff.py);
      bfr  = bfl + signed'(20'(frd_ff.w));
      bfb  = bft + signed'(20'(frd_ff.h));
      box  = bx - bvx;
      boy  = by - bvy;
      bxw  = bx + bw;
      byh  = by + bh;
      boxw = box + bw;
      boyh = boy + bh;
      hit  = (bx < bfr) && (bxw > bfl) && (by < bfb) && (byh > bft);
      hx   = ((boxw <= bfl) && (bxw >= bfl)) || ((box >= bfr) && (bx <= bfr));
      hy   = ((boyh <= bft) && (byh >= bft)) || ((boy >= bfb) && (by <= bfb));
   end

   // Updated moving entry for force, shift and set.
   always_comb begin
      ax        = (bvx < 0) ? -bvx : bvx;
      ay        = (bvy < 0) ? -bvy : bvy;
      lim_s     = signed'(20'(lim_ff));
      apply_ent = work_ff;
      case (op_ff)
         OP_FORCE: begin
            if (ax < lim_s) apply_ent.vx = sat16(bvx + 20'(rx_ff));
            if (ay < lim_s) apply_ent.vy = sat16(bvy + 20'(ry_ff));
         end
         OP_SHIFT: begin
            apply_ent.px = sat16(bx + 20'(cx_ff));
            apply_ent.py = sat16(by + 20'(cy_ff));
         end
         OP_SET: begin
            apply_ent.px = cx_ff;
            apply_ent.py = cy_ff;
         end
         default: apply_ent = work_ff;
      endcase
   end

   always_comb begin
      mre = 1'b0;
      mra = idx_ff[MAW-1:0];
      if (cmd.step == STEP_SCAN_M || cmd.step == STEP_TICK_RD) mre = idx_m_ok;
      fre = 1'b0;
      fra = idx_ff[FAW-1:0];
      if (cmd.step == STEP_SCAN_F) begin
         fre = idx_f_ok;
      end else if (cmd.step == STEP_TICK_F) begin
         fre = fidx_ok;
         fra = fidx_ff[FAW-1:0];
      end
      mwe = 1'b0;
      mwa = widx_ff;
      mwd = work_ff;
      if (add_ok && op_ff == OP_ADD_MOV) begin
         mwe = 1'b1;
         mwa = mcnt_ff[MAW-1:0];
         mwd = '{id: next_id_ff[5:0], px: cx_ff, py: cy_ff, vx: rx_ff, vy: ry_ff,
                 w: w_ff, h: h_ff};
      end else if (cmd.fin == FIN_APPLY_M && op_ff != OP_READ) begin
         mwe = 1'b1;
         mwd = apply_ent;
      end else if (cmd.step == STEP_TICK_WB) begin
         mwe = 1'b1;
      end
      fwe = 1'b0;
      fwa = fwidx_ff;
      fwd = '{id: work_ff.id, px: cx_ff, py: cy_ff, w: work_ff.w, h: work_ff.h};
      if (add_ok && op_ff == OP_ADD_FIX) begin
         fwe = 1'b1;
         fwa = fcnt_ff[FAW-1:0];
         fwd = '{id: next_id_ff[5:0], px: cx_ff, py: cy_ff, w: w_ff, h: h_ff};
      end else if (cmd.fin == FIN_APPLY_F && op_ff == OP_SET) begin
         fwe = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mwe) mov_mem[mwa] <= mwd;
      if (mre) mrd_ff <= mov_mem[mra];
      if (fwe) fix_mem[fwa] <= fwd;
      if (fre) frd_ff <= fix_mem[fra];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff       <= SPEED_LIMIT_RESET;
         mcnt_ff      <= '0;
         fcnt_ff      <= '0;
         next_id_ff   <= '0;
         idx_ff       <= '0;
         fidx_ff      <= '0;
         mrv_ff       <= 1'b0;
         frv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) lim_ff <= csr_write_data;
         if (add_ok) begin
            next_id_ff <= next_id_ff + 7'd1;
            if (op_ff == OP_ADD_MOV) mcnt_ff <= mcnt_ff + MCW'(1);
            else                     fcnt_ff <= fcnt_ff + FCW'(1);
         end
         mrv_ff <= mre;
         frv_ff <= fre;
         case (cmd.step)
            STEP_LOAD, STEP_CLR: idx_ff <= '0;
            STEP_SCAN_M, STEP_TICK_RD: if (idx_m_ok) idx_ff <= idx_ff + ICW'(1);
            STEP_SCAN_F: if (idx_f_ok) idx_ff <= idx_ff + ICW'(1);
            default: ;
         endcase
         if (cmd.step == STEP_TICK_LD) fidx_ff <= '0;
         else if (cmd.step == STEP_TICK_F && fidx_ok) fidx_ff <= fidx_ff + FCW'(1);
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mraddr_ff <= mra;
      fraddr_ff <= fra;
      if (cmd.step == STEP_LOAD) begin
         op_ff  <= req_op;
         id_ff  <= req_body_id;
         cx_ff  <= req_coord_x;
         cy_ff  <= req_coord_y;
         rx_ff  <= req_rate_x;
         ry_ff  <= req_rate_y;
         w_ff   <= req_width;
         h_ff   <= req_height;
         res_ff <= '{status: ST_OK, id: req_body_id, default: '0};
      end
      case (cmd.step)
         STEP_SCAN_M: begin
            if (st.m_match) begin
               work_ff <= mrd_ff;
               widx_ff <= mraddr_ff;
            end
         end
         STEP_SCAN_F: begin
            if (st.f_match) begin
               work_ff <= '{id: frd_ff.id, px: frd_ff.px, py: frd_ff.py,
                            vx: '0, vy: '0, w: frd_ff.w, h: frd_ff.h};
               fwidx_ff <= fraddr_ff;
            end
         end
         STEP_TICK_RD: widx_ff <= idx_ff[MAW-1:0];
         STEP_TICK_LD: begin
            work_ff <= '{id: mrd_ff.id,
                         px: sat16(20'(mrd_ff.px) + 20'(mrd_ff.vx)),
                         py: sat16(20'(mrd_ff.py) + 20'(mrd_ff.vy)),
                         vx: mrd_ff.vx, vy: mrd_ff.vy, w: mrd_ff.w, h: mrd_ff.h};
         end
         STEP_TICK_F: begin
            if (frv_ff && hit) begin
               if (hx) work_ff.vx <= sat16(-bvx);
               if (hy) work_ff.vy <= sat16(-bvy);
            end
         end
         default: ;
      endcase
      case (cmd.fin)
         FIN_ADD: begin
            if (full) begin
               res_ff.status <= ST_FULL;
               res_ff.id     <= '0;
            end else begin
               res_ff.id <= next_id_ff[5:0];
            end
         end
         FIN_NOTFOUND: res_ff.status <= ST_NOTFOUND;
         FIN_APPLY_M: begin
            if (op_ff == OP_READ) begin
               res_ff.px <= work_ff.px;
               res_ff.py <= work_ff.py;
               res_ff.vx <= work_ff.vx;
               res_ff.vy <= work_ff.vy;
               res_ff.w  <= work_ff.w;
               res_ff.h  <= work_ff.h;
            end
         end
         FIN_APPLY_F: begin
            if (op_ff == OP_READ) begin
               res_ff.fixed <= 1'b1;
               res_ff.px    <= work_ff.px;
               res_ff.py    <= work_ff.py;
               res_ff.w     <= work_ff.w;
               res_ff.h     <= work_ff.h;
            end
         end
         default: ;
      endcase
      if (cmd.emit) rsp_ff <= res_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = rsp_ff;

   `ABTS_ASSERT_IMP(a_mcnt_max, 1'b1, mcnt_ff <= MCW'(MOVING_MAX), "moving count overflow")
   `ABTS_ASSERT_IMP(a_fcnt_max, 1'b1, fcnt_ff <= FCW'(FIXED_MAX), "fixed count overflow")
   `ABTS_ASSERT_NXT(a_id_step, add_ok, next_id_ff == $past(next_id_ff) + 7'd1,
                    "identifier counter did not advance on add")

endmodule
`default_nettype wire

// ===== rtl/core/aabb_body_table_stepper_core.sv =====
// Box table stepper top level: one request in, one response out per transfer.
// Adds and op 7 go straight to the response; lookups scan entry by entry; a tick
// reads each moving box, runs it through the whole fixed table and writes it back.
// One request at a time; a finished response may wait while the next is taken.
// Synchronous reset clears counts, the id counter and sets speed_limit to 160.
// Depends on abts_pkg, abts_ctrl and abts_dp.
`timescale 1ns / 1ps
`default_nettype none
module aabb_body_table_stepper_core #(
   parameter int MOVING_MAX = 32,
   parameter int FIXED_MAX  = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [14:0]        csr_write_data,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_op,
   input  wire logic [5:0]         req_body_id,
   input  wire logic signed [15:0] req_coord_x,
   input  wire logic signed [15:0] req_coord_y,
   input  wire logic signed [15:0] req_rate_x,
   input  wire logic signed [15:0] req_rate_y,
   input  wire logic [14:0]        req_width,
   input  wire logic [14:0]        req_height,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [5:0]              rsp_result_id,
   output logic                    rsp_is_fixed,
   output logic signed [15:0]      rsp_out_pos_x,
   output logic signed [15:0]      rsp_out_pos_y,
   output logic signed [15:0]      rsp_out_vel_x,
   output logic signed [15:0]      rsp_out_vel_y,
   output logic [14:0]             rsp_out_width,
   output logic [14:0]             rsp_out_height
);
   import abts_pkg::*;

   // The controller sequences each request; the datapath owns the tables.
   // Both tables are memories with registered reads, so scans and the fixed-table
   // pass of the tick loop advance one entry per cycle.
   cmd_type  cmd;
   stat_type st;
   res_type  res;

   abts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .cmd       (cmd),
      .st        (st)
   );

   abts_dp #(
      .MOVING_MAX (MOVING_MAX),
      .FIXED_MAX  (FIXED_MAX)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_op           (req_op),
      .req_body_id      (req_body_id),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_rate_x       (req_rate_x),
      .req_rate_y       (req_rate_y),
      .req_width        (req_width),
      .req_height       (req_height),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_res          (res),
      .cmd              (cmd),
      .st               (st)
   );

   // The response register unpacks onto separate ports.
   assign rsp_status     = res.status;
   assign rsp_result_id  = res.id;
   assign rsp_is_fixed   = res.fixed;
   assign rsp_out_pos_x  = res.px;
   assign rsp_out_pos_y  = res.py;
   assign rsp_out_vel_x  = res.vx;
   assign rsp_out_vel_y  = res.vy;
   assign rsp_out_width  = res.w;
   assign rsp_out_height = res.h;

endmodule
`default_nettype wire

// ===== tb/sv/tb_aabb_body_table_stepper_core.sv =====
// Self-checking testbench for the box table stepper core.
// Drives a directed table and random op mixes through a predictor of the box tables.
// Depends on abts_pkg and the aabb_body_table_stepper_core RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_aabb_body_table_stepper_core;
   import abts_pkg::*;

   localparam int MOV_DEPTH = 32;
   localparam int FIX_DEPTH = 32;
   // The one op code that the block ignores.
   localparam logic [2:0] OP_UNUSED = 3'd7;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [14:0] csr_write_data;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_op;
   logic [5:0] req_body_id;
   logic signed [15:0] req_coord_x, req_coord_y, req_rate_x, req_rate_y;
   logic [14:0] req_width, req_height;
   logic rsp_valid;
   logic rsp_stall;
   logic [1:0] rsp_status;
   logic [5:0] rsp_result_id;
   logic rsp_is_fixed;
   logic signed [15:0] rsp_out_pos_x, rsp_out_pos_y, rsp_out_vel_x, rsp_out_vel_y;
   logic [14:0] rsp_out_width, rsp_out_height;

   aabb_body_table_stepper_core i_dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_body_id(req_body_id), .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_rate_x(req_rate_x), .req_rate_y(req_rate_y),
      .req_width(req_width), .req_height(req_height),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_result_id(rsp_result_id), .rsp_is_fixed(rsp_is_fixed),
      .rsp_out_pos_x(rsp_out_pos_x), .rsp_out_pos_y(rsp_out_pos_y),
      .rsp_out_vel_x(rsp_out_vel_x), .rsp_out_vel_y(rsp_out_vel_y),
      .rsp_out_width(rsp_out_width), .rsp_out_height(rsp_out_height)
   );

   // One request as it crosses the input channel.
   typedef struct {
      logic [2:0] op;
      logic [5:0] id;
      logic signed [15:0] cx, cy, rx, ry;
      logic [14:0] w, h;
   } box_req_type;

   // A directed row: the request and, where it can be read off directly, the
   // response that must come back.
   typedef struct {
      box_req_type rq;
      bit known;
      res_type res;
   } row_type;

   // Shadow copy of the box tables and the speed limit.
   mov_ent_type shadow_mov[MOV_DEPTH];
   fix_ent_type shadow_fix[FIX_DEPTH];
   int shadow_mov_count, shadow_fix_count, shadow_next_id;
   logic [14:0] shadow_limit;

   res_type pending_rsp[$];
   int mismatches;
   bit failed;
   bit rsp_random_stall;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The run ends here if the handshakes ever hang.
   initial begin
      #60ms;
      $display("Verification failed");
      $finish;
   end

   function automatic logic signed [15:0] clamp16(input int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic int find_mov(input logic [5:0] id);
      for (int i = 0; i < shadow_mov_count; i++)
         if (shadow_mov[i].id == id) return i;
      return -1;
   endfunction

   function automatic int find_fix(input logic [5:0] id);
      for (int i = 0; i < shadow_fix_count; i++)
         if (shadow_fix[i].id == id) return i;
      return -1;
   endfunction

   // Reverses the velocity axes on which a moving box crossed an edge of a
   // fixed box; all edge sums are done in 32-bit integers so nothing wraps.
   task automatic bounce_box(input int m, input int f);
      int x, y, vx, vy, w, h, fl, ft, fr, fb, ox, oy;
      bit hx, hy;
      x = shadow_mov[m].px; y = shadow_mov[m].py;
      vx = shadow_mov[m].vx; vy = shadow_mov[m].vy;
      w = shadow_mov[m].w; h = shadow_mov[m].h;
      fl = shadow_fix[f].px; ft = shadow_fix[f].py;
      fr = fl + int'(shadow_fix[f].w); fb = ft + int'(shadow_fix[f].h);
      ox = x - vx; oy = y - vy;
      if (!(x < fr && x + w > fl && y < fb && y + h > ft)) return;
      hx = (ox + w <= fl && x + w >= fl) || (ox >= fr && x <= fr);
      hy = (oy + h <= ft && y + h >= ft) || (oy >= fb && y <= fb);
      if (hx) shadow_mov[m].vx = clamp16(-vx);
      if (hy) shadow_mov[m].vy = clamp16(-vy);
   endtask

   // Applies one request to the shadow tables and returns the response.
   task automatic predict_box_op(input box_req_type rq, output res_type r);
      int k, ax, ay;
      r = '0;
      r.id = rq.id;
      r.status = ST_OK;
      case (rq.op)
         OP_ADD_MOV, OP_ADD_FIX: begin
            if (shadow_next_id >= int'(ID_SPACE) ||
                (rq.op == OP_ADD_MOV && shadow_mov_count >= MOV_DEPTH) ||
                (rq.op == OP_ADD_FIX && shadow_fix_count >= FIX_DEPTH)) begin
               r.status = ST_FULL;
               r.id = '0;
            end else begin
               r.id = shadow_next_id[5:0];
               if (rq.op == OP_ADD_MOV) begin
                  shadow_mov[shadow_mov_count] = '{r.id, rq.cx, rq.cy, rq.rx, rq.ry,
                                                   rq.w, rq.h};
                  shadow_mov_count++;
               end else begin
                  shadow_fix[shadow_fix_count] = '{r.id, rq.cx, rq.cy, rq.w, rq.h};
                  shadow_fix_count++;
               end
               shadow_next_id++;
            end
         end
         OP_FORCE: begin
            k = find_mov(rq.id);
            if (k < 0) begin
               r.status = ST_NOTFOUND;
            end else begin
               ax = shadow_mov[k].vx; ay = shadow_mov[k].vy;
               if (ax < 0) ax = -ax;
               if (ay < 0) ay = -ay;
               if (ax < int'(shadow_limit))
                  shadow_mov[k].vx = clamp16(int'(shadow_mov[k].vx) + int'(rq.rx));
               if (ay < int'(shadow_limit))
                  shadow_mov[k].vy = clamp16(int'(shadow_mov[k].vy) + int'(rq.ry));
            end
         end
         OP_SHIFT: begin
            k = find_mov(rq.id);
            if (k < 0) begin
               r.status = ST_NOTFOUND;
            end else begin
               shadow_mov[k].px = clamp16(int'(shadow_mov[k].px) + int'(rq.cx));
               shadow_mov[k].py = clamp16(int'(shadow_mov[k].py) + int'(rq.cy));
            end
         end
         OP_SET: begin
            k = find_mov(rq.id);
            if (k >= 0) begin
               shadow_mov[k].px = rq.cx; shadow_mov[k].py = rq.cy;
            end else begin
               k = find_fix(rq.id);
               if (k < 0) begin
                  r.status = ST_NOTFOUND;
               end else begin
                  shadow_fix[k].px = rq.cx; shadow_fix[k].py = rq.cy;
               end
            end
         end
         OP_TICK: begin
            for (int i = 0; i < shadow_mov_count; i++) begin
               shadow_mov[i].px = clamp16(int'(shadow_mov[i].px) + int'(shadow_mov[i].vx));
               shadow_mov[i].py = clamp16(int'(shadow_mov[i].py) + int'(shadow_mov[i].vy));
               for (int j = 0; j < shadow_fix_count; j++) bounce_box(i, j);
            end
         end
         OP_READ: begin
            k = find_mov(rq.id);
            if (k >= 0) begin
               r.px = shadow_mov[k].px; r.py = shadow_mov[k].py;
               r.vx = shadow_mov[k].vx; r.vy = shadow_mov[k].vy;
               r.w = shadow_mov[k].w; r.h = shadow_mov[k].h;
            end else begin
               k = find_fix(rq.id);
               if (k < 0) begin
                  r.status = ST_NOTFOUND;
               end else begin
                  r.fixed = 1'b1;
                  r.px = shadow_fix[k].px; r.py = shadow_fix[k].py;
                  r.w = shadow_fix[k].w; r.h = shadow_fix[k].h;
               end
            end
         end
         default: ;
      endcase
   endtask

   // Presents one request and holds it until the transfer happens; the
   // predicted response is queued at the accepting edge.
   task automatic send_box_req(input box_req_type rq, input bit known, input res_type kr);
      res_type r;
      req_op <= rq.op; req_body_id <= rq.id;
      req_coord_x <= rq.cx; req_coord_y <= rq.cy;
      req_rate_x <= rq.rx; req_rate_y <= rq.ry;
      req_width <= rq.w; req_height <= rq.h;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_box_op(rq, r);
      if (known && r !== kr) begin
         // The typed-in answer and the predictor disagree; trust neither.
         failed = 1'b1;
         $display("directed row disagrees with predictor: op %0d id %0d", rq.op, rq.id);
      end
      pending_rsp = {pending_rsp, r};
   endtask

   // Random gap of idle cycles after a burst; valid is also dropped while draining.
   task automatic idle_gap(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // The register may only change with no request in flight.
   task automatic write_limit(input logic [14:0] v);
      drain_all();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_limit = v;
   endtask

   function automatic logic signed [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'(16'sh7fff - $urandom_range(0, 64));
         1: return 16'(16'sh8000 + $urandom_range(0, 64));
         2: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 1600)) - 800);
      endcase
   endfunction

   function automatic logic signed [15:0] rand_rate();
      case ($urandom_range(0, 4))
         0: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 320)) - 160);
      endcase
   endfunction

   function automatic logic [14:0] rand_size();
      if ($urandom_range(0, 7) == 0) return 15'($urandom);
      return 15'($urandom_range(0, 800));
   endfunction

   // Mostly valid ids so that lookups hit; a few stray ones exercise misses.
   function automatic box_req_type rand_box_req();
      box_req_type rq;
      int pick;
      rq.cx = rand_coord(); rq.cy = rand_coord();
      rq.rx = rand_rate(); rq.ry = rand_rate();
      rq.w = rand_size(); rq.h = rand_size();
      pick = $urandom_range(0, 99);
      if (pick < 14) rq.op = OP_ADD_MOV;
      else if (pick < 24) rq.op = OP_ADD_FIX;
      else if (pick < 40) rq.op = OP_FORCE;
      else if (pick < 52) rq.op = OP_SHIFT;
      else if (pick < 62) rq.op = OP_SET;
      else if (pick < 72) rq.op = OP_TICK;
      else if (pick < 97) rq.op = OP_READ;
      else rq.op = OP_UNUSED;
      if (shadow_next_id > 0 && $urandom_range(0, 9) != 0)
         rq.id = 6'($urandom_range(0, shadow_next_id - 1));
      else
         rq.id = 6'($urandom);
      return rq;
   endfunction

   // Receiver: stalls at random on its own pattern, and never while random stalls are off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_random_stall) begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Response checker: compares each transfer with the oldest prediction.
   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10) $display("response with nothing pending");
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status || rsp_result_id !== want.id ||
                rsp_is_fixed !== want.fixed || rsp_out_pos_x !== want.px ||
                rsp_out_pos_y !== want.py || rsp_out_vel_x !== want.vx ||
                rsp_out_vel_y !== want.vy || rsp_out_width !== want.w ||
                rsp_out_height !== want.h) begin
               failed = 1'b1;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st %0d id %0d fx %0d p %0d,%0d v %0d,%0d s %0d,%0d",
                           want.status, want.id, want.fixed, want.px, want.py,
                           want.vx, want.vy, want.w, want.h,
                           " got st %0d id %0d fx %0d p %0d,%0d v %0d,%0d s %0d,%0d",
                           rsp_status, rsp_result_id, rsp_is_fixed, rsp_out_pos_x,
                           rsp_out_pos_y, rsp_out_vel_x, rsp_out_vel_y,
                           rsp_out_width, rsp_out_height);
            end
         end
      end
   end

   initial begin
      row_type rows[$];
      row_type rw;
      box_req_type rq;
      res_type none;
      int burst, sent, waited;
      none = '0;
      mismatches = 0;
      failed = 1'b0;
      rsp_random_stall = 1'b0;
      shadow_mov_count = 0; shadow_fix_count = 0; shadow_next_id = 0;
      shadow_limit = SPEED_LIMIT_RESET;
      reset = 1'b1;
      csr_write_enable = 1'b0; csr_write_data = '0;
      req_valid = 1'b0; req_op = '0; req_body_id = '0;
      req_coord_x = '0; req_coord_y = '0; req_rate_x = '0; req_rate_y = '0;
      req_width = '0; req_height = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table. Known answers: misses on an empty table, the first
      // ids, extreme sizes and the unused op.
      rw.known = 1'b1;
      rw.rq = '{OP_READ, 6'd63, 0, 0, 0, 0, 0, 0};
      rw.res = '{ST_NOTFOUND, 6'd63, 0, 0, 0, 0, 0, 0, 0}; rows = {rows, rw};
      rw.rq = '{OP_FORCE, 6'd0, 0, 0, 1, 1, 0, 0};
      rw.res = '{ST_NOTFOUND, 6'd0, 0, 0, 0, 0, 0, 0, 0}; rows = {rows, rw};
      rw.rq = '{OP_UNUSED, 6'd42, 0, 0, 0, 0, 0, 0};
      rw.res = '{ST_OK, 6'd42, 0, 0, 0, 0, 0, 0, 0}; rows = {rows, rw};
      rw.rq = '{OP_ADD_MOV, 6'd63, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                15'h7fff, 15'h7fff};
      rw.res = '{ST_OK, 6'd0, 0, 0, 0, 0, 0, 0, 0}; rows = {rows, rw};
      rw.rq = '{OP_READ, 6'd0, 0, 0, 0, 0, 0, 0};
      rw.res = '{ST_OK, 6'd0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                 15'h7fff, 15'h7fff}; rows = {rows, rw};
      rw.rq = '{OP_ADD_FIX, 6'd0, 16'sh8000, 16'sh7fff, 0, 0, 15'd0, 15'd0};
      rw.res = '{ST_OK, 6'd1, 0, 0, 0, 0, 0, 0, 0}; rows = {rows, rw};
      rw.rq = '{OP_READ, 6'd1, 0, 0, 0, 0, 0, 0};
      rw.res = '{ST_OK, 6'd1, 1, 16'sh8000, 16'sh7fff, 0, 0, 0, 0}; rows = {rows, rw};
      rw.rq = '{OP_SHIFT, 6'd1, 1, 1, 0, 0, 0, 0};
      rw.res = '{ST_NOTFOUND, 6'd1, 0, 0, 0, 0, 0, 0, 0}; rows = {rows, rw};
      // The rest come from the predictor: saturation on shift and tick,
      // force above and below the limit, a bounce against a wall.
      rw.known = 1'b0; rw.res = none;
      rw.rq = '{OP_SHIFT, 6'd0, 16'sh7fff, 16'sh8000, 0, 0, 0, 0}; rows = {rows, rw};
      rw.rq = '{OP_FORCE, 6'd0, 0, 0, 16'sh7fff, 16'sh7fff, 0, 0}; rows = {rows, rw};
      rw.rq = '{OP_TICK, 6'd0, 0, 0, 0, 0, 0, 0}; rows = {rows, rw};
      rw.rq = '{OP_ADD_MOV, 6'd0, 16'sd0, 16'sd0, 16'sd40, -16'sd40, 15'd64, 15'd64};
      rows = {rows, rw};
      rw.rq = '{OP_ADD_FIX, 6'd0, 16'sd80, -16'sd200, 0, 0, 15'd200, 15'd600};
      rows = {rows, rw};
      rw.rq = '{OP_FORCE, 6'd2, 0, 0, -16'sd8, 16'sd8, 0, 0}; rows = {rows, rw};
      rw.rq = '{OP_TICK, 6'd0, 0, 0, 0, 0, 0, 0}; rows = {rows, rw};
      rw.rq = '{OP_READ, 6'd2, 0, 0, 0, 0, 0, 0}; rows = {rows, rw};
      rw.rq = '{OP_SET, 6'd3, 16'sd100, 16'sd100, 0, 0, 0, 0}; rows = {rows, rw};
      rw.rq = '{OP_SET, 6'd2, -16'sd100, 16'sd0, 0, 0, 0, 0}; rows = {rows, rw};
      rw.rq = '{OP_TICK, 6'd0, 0, 0, 0, 0, 0, 0}; rows = {rows, rw};
      rw.rq = '{OP_READ, 6'd2, 0, 0, 0, 0, 0, 0}; rows = {rows, rw};
      rw.rq = '{OP_SET, 6'd50, 0, 0, 0, 0, 0, 0}; rows = {rows, rw};

      foreach (rows[i]) send_box_req(rows[i].rq, rows[i].known, rows[i].res);

      // Random part in phases, each with its own speed limit; the first two
      // use the extremes. A reset-free run reaches the id limit, so adds keep
      // returning table full afterwards.
      rsp_random_stall = 1'b1;
      sent = 0;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_limit(15'd0);
            1: write_limit(15'h7fff);
            2: write_limit(15'd100);
            3: write_limit(15'($urandom_range(1, 400)));
            default: write_limit(SPEED_LIMIT_RESET);
         endcase
         rsp_random_stall = (phase != 2);
         while (sent < (phase + 1) * 116) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
               rq = rand_box_req();
               send_box_req(rq, 1'b0, none);
               sent++;
            end
            if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 20));
         end
         // Hold off once until the block has answered everything.
         if (phase == 1) drain_all();
      end

      req_valid <= 1'b0;
      waited = 0;
      while (pending_rsp.size() != 0 && waited < 2000000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (!failed && pending_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
